@@ rtl/starfield_projection_step_assert.svh @@
// ----------------------------------------------------------------------------
// starfield_projection_step_assert.svh
// Assertion macros used by the starfield RTL. Each one samples on clk_i and
// is quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STARFIELD_PROJECTION_STEP_ASSERT_SVH
`define STARFIELD_PROJECTION_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, constants and small helpers of the starfield projection block.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned PADDR_W    = 16;
  localparam int unsigned COLOUR_W   = 8;
  localparam int unsigned COL_W      = 9;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned OFF_W      = 17;
  localparam int unsigned WORLD_W    = 3 * COORD_W;
  localparam int unsigned SCREEN_W   = COL_W + ROW_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [COORD_W-1:0]  RESPAWN_DEPTH = 16'd500;
  localparam logic [OFF_W-1:0]    GUARD_LO      = 17'd640;
  localparam logic [OFF_W-1:0]    GUARD_HI      = 17'd63360;
  localparam logic [COLOUR_W-1:0] SHADE_STEP    = 8'd72;
  localparam logic [COLOUR_W-1:0] SHADE_STEP2   = 8'd144;
  localparam logic [COLOUR_W-1:0] ERASE_COLOUR  = 8'd0;
  localparam logic [CFG_DATA_W-1:0] SPEED_RESET   = 8'd2;
  localparam logic [CFG_DATA_W-1:0] PALETTE_RESET = 8'd32;

  // Pixel counter positions within one plus shape.
  localparam logic [3:0] PIX_ERASE_SPLIT = 4'd7;
  localparam logic [3:0] PIX_LAST        = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAR_SPEED   = 1'b0,
    CFG_PALETTE_BASE = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_ERASE,
    S_DIV,
    S_PROJ,
    S_UPDATE,
    S_TAIL,
    S_DRAW
  } sfp_state_e;

  // Frame offset of a screen position: col + 320 * row.
  function automatic logic [OFF_W-1:0] frame_offset(logic [COL_W-1:0] col,
                                                    logic [ROW_W-1:0] row);
    frame_offset = {1'b0, row, 8'd0} + {3'd0, row, 6'd0} + {8'd0, col};
  endfunction

  function automatic logic in_guard(logic [OFF_W-1:0] off);
    in_guard = (off >= GUARD_LO) && (off < GUARD_HI);
  endfunction

  // Erase order: centre, -1, +1, -2, +2, -320, +320, -640, +640.
  function automatic logic [PADDR_W-1:0] erase_offset(logic [3:0] k);
    case (k)
      4'd0:    erase_offset = 16'd0;
      4'd1:    erase_offset = -16'd1;
      4'd2:    erase_offset = 16'd1;
      4'd3:    erase_offset = -16'd2;
      4'd4:    erase_offset = 16'd2;
      4'd5:    erase_offset = -16'd320;
      4'd6:    erase_offset = 16'd320;
      4'd7:    erase_offset = -16'd640;
      4'd8:    erase_offset = 16'd640;
      default: erase_offset = 16'd0;
    endcase
  endfunction

  // Draw order: centre, -1, +1, -320, +320, -2, +2, -640, +640.
  function automatic logic [PADDR_W-1:0] draw_offset(logic [3:0] k);
    case (k)
      4'd0:    draw_offset = 16'd0;
      4'd1:    draw_offset = -16'd1;
      4'd2:    draw_offset = 16'd1;
      4'd3:    draw_offset = -16'd320;
      4'd4:    draw_offset = 16'd320;
      4'd5:    draw_offset = -16'd2;
      4'd6:    draw_offset = 16'd2;
      4'd7:    draw_offset = -16'd640;
      4'd8:    draw_offset = 16'd640;
      default: draw_offset = 16'd0;
    endcase
  endfunction

endpackage

@@ rtl/sfp_ram.sv @@
// ----------------------------------------------------------------------------
// sfp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sfp_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/starfield_projection_step.sv @@
// ----------------------------------------------------------------------------
// starfield_projection_step
// Perspective starfield: advances one star per item and emits the pixel
// erases and shaded pixel writes that the move causes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries a star index and the
//   spawn coordinates used if that star respawns. Output channel
//   (out_valid_o / out_ready_i) carries one pixel write per transfer, with
//   last_of_run_o set on the final pixel of a star. Items that cause no
//   pixel produce no transfer. The config channel writes star_speed
//   (index 0) and palette_base (index 1); it is always ready.
//   Stars are worked one at a time, paced by the two-bit-per-cycle divider
//   and the single pixel result port (one pixel per cycle while the
//   receiver is ready). The first erase pixel passes the input buffer,
//   the table read, S_LOAD, S_ERASE and the output register.
//   One input item is buffered while the previous star is in flight.
//   Reset: the star tables are swept, one entry per cycle, over all
//   STAR_COUNT entries; in_ready_o stays low during the sweep.
//   A stalled receiver holds the output register and freezes the sequencer in its pixel states.
// ----------------------------------------------------------------------------
`include "starfield_projection_step_assert.svh"

module starfield_projection_step #(
  parameter int unsigned STAR_COUNT = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sfp_pkg::IDX_W-1:0]             star_index_i,
  input  logic signed [sfp_pkg::COORD_W-1:0]    spawn_x_i,
  input  logic signed [sfp_pkg::COORD_W-1:0]    spawn_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [sfp_pkg::PADDR_W-1:0]           pixel_address_o,
  output logic [sfp_pkg::COLOUR_W-1:0]          pixel_colour_o,
  output logic                                  last_of_run_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(STAR_COUNT - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [sfp_pkg::CFG_DATA_W-1:0] speed_q;
  logic [sfp_pkg::COLOUR_W-1:0]          palette_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= sfp_pkg::SPEED_RESET;
      palette_q <= sfp_pkg::PALETTE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sfp_pkg::CFG_STAR_SPEED:   speed_q   <= cfg_data_i;
        sfp_pkg::CFG_PALETTE_BASE: palette_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  sfp_pkg::sfp_state_e state_q, state_d;
  logic [3:0]          pix_q, pix_d;
  logic [AW-1:0]       clr_q;

  // Input buffer: one item waits here while the previous star is worked on.
  logic                                hold_valid_q;
  logic [sfp_pkg::IDX_W-1:0]           hold_idx_q;
  logic signed [sfp_pkg::COORD_W-1:0]  hold_sx_q, hold_sy_q;
  logic                                hold_take;
  logic                                hold_in_range;

  // Work registers of the star in flight.
  logic [AW-1:0]                       wk_addr_q;
  logic signed [sfp_pkg::COORD_W-1:0]  wk_x_q, wk_y_q, wk_z_q;
  logic signed [sfp_pkg::COORD_W-1:0]  wk_sx_q, wk_sy_q;
  logic                                erase_en_q;
  logic [sfp_pkg::PADDR_W-1:0]         erase_base_q;

  // Divider lanes: lane 0 for x, lane 1 for y.
  logic                                div_busy_q;
  logic [2:0]                          div_cnt_q;
  logic [sfp_pkg::COORD_W-1:0]         div_acc_q [2];
  logic [sfp_pkg::COORD_W-2:0]         div_rem_q [2];
  logic [sfp_pkg::COORD_W-1:0]         div_acc_d [2];
  logic [sfp_pkg::COORD_W-2:0]         div_rem_d [2];
  logic                                div_neg_q [2];
  logic [sfp_pkg::COORD_W-2:0]         div_den_q;

  // Projection results.
  logic                                offscr_q;
  logic [sfp_pkg::COL_W-1:0]           col_q;
  logic [sfp_pkg::ROW_W-1:0]           row_q;
  logic [sfp_pkg::COORD_W-1:0]         nz_q;

  // Draw parameters.
  logic                                draw_en_q, draw_en_d;
  logic [sfp_pkg::PADDR_W-1:0]         draw_base_q;
  logic [sfp_pkg::COLOUR_W-1:0]        colour_q, colour_d;
  logic [sfp_pkg::OFF_W-1:0]           draw_off;

  // Output register.
  logic                                out_valid_q;
  logic [sfp_pkg::PADDR_W-1:0]         out_addr_q;
  logic [sfp_pkg::COLOUR_W-1:0]        out_colour_q;
  logic                                out_last_q;
  logic                                out_free;

  // Sequencer outputs.
  logic                                emit;
  logic [sfp_pkg::PADDR_W-1:0]         emit_addr;
  logic [sfp_pkg::COLOUR_W-1:0]        emit_colour;
  logic                                emit_last;

  // Memory ports.
  logic                                mem_re;
  logic                                wld_we, scr_we;
  logic [AW-1:0]                       mem_waddr;
  logic [sfp_pkg::WORLD_W-1:0]         wld_wdata, wld_rdata;
  logic [sfp_pkg::SCREEN_W-1:0]        scr_wdata, scr_rdata;

  // Load and projection arithmetic.
  logic signed [sfp_pkg::COORD_W-1:0]  ld_x, ld_y, ld_z;
  logic [sfp_pkg::COL_W-1:0]           ld_col;
  logic [sfp_pkg::ROW_W-1:0]           ld_row;
  logic [sfp_pkg::OFF_W-1:0]           ld_off;
  logic                                ld_z_ok;
  logic signed [17:0]                  qx_s, qy_s, col_s, row_s, nz_s;
  logic                                offscr_d;

  // --------------------------------------------------------------------------
  // Star tables
  // --------------------------------------------------------------------------
  sfp_ram #(
    .WIDTH  (sfp_pkg::WORLD_W),
    .DEPTH  (STAR_COUNT),
    .ADDR_W (AW)
  ) u_world_ram (
    .clk_i   (clk_i),
    .we_i    (wld_we),
    .waddr_i (mem_waddr),
    .wdata_i (wld_wdata),
    .re_i    (mem_re),
    .raddr_i (AW'(hold_idx_q)),
    .rdata_o (wld_rdata)
  );

  sfp_ram #(
    .WIDTH  (sfp_pkg::SCREEN_W),
    .DEPTH  (STAR_COUNT),
    .ADDR_W (AW)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (mem_waddr),
    .wdata_i (scr_wdata),
    .re_i    (mem_re),
    .raddr_i (AW'(hold_idx_q)),
    .rdata_o (scr_rdata)
  );

  // --------------------------------------------------------------------------
  // Input buffer
  // --------------------------------------------------------------------------
  assign in_ready_o    = (state_q != sfp_pkg::S_CLEAR) && !hold_valid_q;
  assign hold_in_range = 32'(hold_idx_q) < STAR_COUNT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      hold_valid_q <= 1'b1;
    end else if (hold_take) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hold_idx_q <= star_index_i;
      hold_sx_q  <= spawn_x_i;
      hold_sy_q  <= spawn_y_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    pix_d   = pix_q;
    case (state_q)
      sfp_pkg::S_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = sfp_pkg::S_IDLE;
        end
      end
      sfp_pkg::S_IDLE: begin
        // Drop a star index beyond the table; no state change, no pixels.
        if (hold_valid_q && hold_in_range) begin
          state_d = sfp_pkg::S_LOAD;
        end
      end
      sfp_pkg::S_LOAD: begin
        pix_d   = 4'd0;
        state_d = sfp_pkg::in_guard(ld_off) ? sfp_pkg::S_ERASE : sfp_pkg::S_DIV;
      end
      sfp_pkg::S_ERASE: begin
        if (out_free) begin
          pix_d = pix_q + 4'd1;
          if (pix_q == sfp_pkg::PIX_ERASE_SPLIT) begin
            state_d = sfp_pkg::S_DIV;
          end
        end
      end
      sfp_pkg::S_DIV: begin
        if (!div_busy_q) begin
          state_d = sfp_pkg::S_PROJ;
        end
      end
      sfp_pkg::S_PROJ: begin
        state_d = sfp_pkg::S_UPDATE;
      end
      sfp_pkg::S_UPDATE: begin
        pix_d = 4'd0;
        if (erase_en_q) begin
          state_d = sfp_pkg::S_TAIL;
        end else if (draw_en_d) begin
          state_d = sfp_pkg::S_DRAW;
        end else begin
          state_d = sfp_pkg::S_IDLE;
        end
      end
      sfp_pkg::S_TAIL: begin
        if (out_free) begin
          state_d = draw_en_q ? sfp_pkg::S_DRAW : sfp_pkg::S_IDLE;
        end
      end
      sfp_pkg::S_DRAW: begin
        if (out_free) begin
          pix_d = pix_q + 4'd1;
          if (pix_q == sfp_pkg::PIX_LAST) begin
            state_d = sfp_pkg::S_IDLE;
          end
        end
      end
      default: state_d = sfp_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    emit        = 1'b0;
    emit_addr   = erase_base_q + sfp_pkg::erase_offset(pix_q);
    emit_colour = sfp_pkg::ERASE_COLOUR;
    emit_last   = 1'b0;
    mem_re      = 1'b0;
    hold_take   = 1'b0;
    wld_we      = 1'b0;
    scr_we      = 1'b0;
    case (state_q)
      sfp_pkg::S_CLEAR: begin
        wld_we = 1'b1;
        scr_we = 1'b1;
      end
      sfp_pkg::S_IDLE: begin
        hold_take = hold_valid_q;
        mem_re    = hold_valid_q && hold_in_range;
      end
      sfp_pkg::S_ERASE: begin
        emit = out_free;
      end
      sfp_pkg::S_UPDATE: begin
        // Write back the star; screen position only when it stays on screen.
        wld_we = 1'b1;
        scr_we = !offscr_q;
      end
      sfp_pkg::S_TAIL: begin
        // Hold the ninth erase pixel until the draw decision sets its last flag.
        emit      = out_free;
        emit_addr = erase_base_q + sfp_pkg::erase_offset(sfp_pkg::PIX_LAST);
        emit_last = !draw_en_q;
      end
      sfp_pkg::S_DRAW: begin
        emit      = out_free;
        emit_addr = draw_base_q + sfp_pkg::draw_offset(pix_q);
        emit_last = (pix_q == sfp_pkg::PIX_LAST);
        if (pix_q == 4'd0) begin
          emit_colour = colour_q;
        end else if (pix_q <= 4'd4) begin
          emit_colour = colour_q + sfp_pkg::SHADE_STEP;
        end else begin
          emit_colour = colour_q + sfp_pkg::SHADE_STEP2;
        end
      end
      default: ;
    endcase
  end

  // Clear sweep writes x = y = 0 and depth = index + 1.
  assign mem_waddr = (state_q == sfp_pkg::S_CLEAR) ? clr_q : wk_addr_q;

  always_comb begin
    if (state_q == sfp_pkg::S_CLEAR) begin
      wld_wdata = {32'd0, 16'(clr_q) + 16'd1};
      scr_wdata = '0;
    end else begin
      wld_wdata = offscr_q ? {wk_sx_q, wk_sy_q, sfp_pkg::RESPAWN_DEPTH}
                           : {wk_x_q, wk_y_q, nz_q};
      scr_wdata = {col_q, row_q};
    end
  end

  // --------------------------------------------------------------------------
  // Load: unpack the table entries, set up the erase and the dividers
  // --------------------------------------------------------------------------
  assign ld_x    = wld_rdata[47:32];
  assign ld_y    = wld_rdata[31:16];
  assign ld_z    = wld_rdata[15:0];
  assign ld_col  = scr_rdata[16:8];
  assign ld_row  = scr_rdata[7:0];
  assign ld_off  = sfp_pkg::frame_offset(ld_col, ld_row);
  assign ld_z_ok = !ld_z[15] && (ld_z != 16'sd0);

  // Two restoring steps per cycle per lane, quotient bits shift into acc.
  always_comb begin
    logic [sfp_pkg::COORD_W-1:0] acc_t;
    logic [sfp_pkg::COORD_W-2:0] rem_t;
    logic [sfp_pkg::COORD_W-1:0] r_t;
    for (int l = 0; l < 2; l++) begin
      acc_t = div_acc_q[l];
      rem_t = div_rem_q[l];
      for (int s = 0; s < 2; s++) begin
        r_t   = {rem_t, acc_t[15]};
        acc_t = {acc_t[14:0], 1'b0};
        if (r_t >= {1'b0, div_den_q}) begin
          r_t      = r_t - {1'b0, div_den_q};
          acc_t[0] = 1'b1;
        end
        rem_t = r_t[14:0];
      end
      div_acc_d[l] = acc_t;
      div_rem_d[l] = rem_t;
    end
  end

  // --------------------------------------------------------------------------
  // Projection: apply sign, add screen centre, advance depth
  // --------------------------------------------------------------------------
  assign qx_s  = div_neg_q[0] ? 18'sd0 - $signed({2'b00, div_acc_q[0]})
                              : $signed({2'b00, div_acc_q[0]});
  assign qy_s  = div_neg_q[1] ? 18'sd0 - $signed({2'b00, div_acc_q[1]})
                              : $signed({2'b00, div_acc_q[1]});
  assign col_s = qx_s + 18'sd160;
  assign row_s = qy_s + 18'sd100;

  always_comb begin
    nz_s = 18'(wk_z_q) - 18'(speed_q);
    // Saturate depth when a negative speed pushes it past the signed range.
    if (nz_s > 18'sd32767) begin
      nz_s = 18'sd32767;
    end
    offscr_d = (nz_s <= 18'sd0) || (row_s < 18'sd1) || (row_s > 18'sd198) ||
               (col_s < 18'sd1) || (col_s > 18'sd318);
  end

  // --------------------------------------------------------------------------
  // Update: draw offset, guard band and centre colour
  // --------------------------------------------------------------------------
  assign draw_off  = sfp_pkg::frame_offset(col_q, row_q);
  assign draw_en_d = !offscr_q && sfp_pkg::in_guard(draw_off);
  assign colour_d  = palette_q + {3'd0, nz_q[8:4]};

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfp_pkg::S_CLEAR;
      pix_q       <= 4'd0;
      clr_q       <= '0;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= 3'd0;
      erase_en_q  <= 1'b0;
      draw_en_q   <= 1'b0;
      offscr_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pix_q   <= pix_d;
      if (state_q == sfp_pkg::S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == sfp_pkg::S_LOAD) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= 3'd0;
        erase_en_q <= sfp_pkg::in_guard(ld_off);
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + 3'd1;
        if (div_cnt_q == 3'd7) begin
          div_busy_q <= 1'b0;
        end
      end
      if (state_q == sfp_pkg::S_PROJ) begin
        offscr_q <= offscr_d;
      end
      if (state_q == sfp_pkg::S_UPDATE) begin
        draw_en_q <= draw_en_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (hold_take) begin
      wk_addr_q <= AW'(hold_idx_q);
      wk_sx_q   <= hold_sx_q;
      wk_sy_q   <= hold_sy_q;
    end
    if (state_q == sfp_pkg::S_LOAD) begin
      wk_x_q       <= ld_x;
      wk_y_q       <= ld_y;
      wk_z_q       <= ld_z;
      erase_base_q <= ld_off[15:0];
      div_neg_q[0] <= ld_x[15];
      div_neg_q[1] <= ld_y[15];
      div_acc_q[0] <= ld_z_ok ? (ld_x[15] ? 16'd0 - ld_x : ld_x) : 16'd0;
      div_acc_q[1] <= ld_z_ok ? (ld_y[15] ? 16'd0 - ld_y : ld_y) : 16'd0;
      div_rem_q[0] <= '0;
      div_rem_q[1] <= '0;
      div_den_q    <= ld_z_ok ? ld_z[14:0] : 15'd1;
    end else if (div_busy_q) begin
      div_acc_q[0] <= div_acc_d[0];
      div_acc_q[1] <= div_acc_d[1];
      div_rem_q[0] <= div_rem_d[0];
      div_rem_q[1] <= div_rem_d[1];
    end
    if (state_q == sfp_pkg::S_PROJ) begin
      col_q <= col_s[8:0];
      row_q <= row_s[7:0];
      nz_q  <= nz_s[15:0];
    end
    if (state_q == sfp_pkg::S_UPDATE) begin
      draw_base_q <= draw_off[15:0];
      colour_q    <= colour_d;
    end
    if (emit) begin
      out_addr_q   <= emit_addr;
      out_colour_q <= emit_colour;
      out_last_q   <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_colour_o  = out_colour_q;
  assign last_of_run_o   = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SFP_ASSERT_NOW(a_no_rw_same_cycle, mem_re, !wld_we, "table read overlaps write-back")
  `SFP_ASSERT_NOW(a_hold_empty_in_clear, state_q == sfp_pkg::S_CLEAR, !hold_valid_q,
                  "item buffered during table clear")
  `SFP_ASSERT_NOW(a_div_done_at_proj, state_q == sfp_pkg::S_PROJ, !div_busy_q,
                  "projection taken before divider finished")
  `SFP_ASSERT_NEXT(a_last_ends_star, emit && emit_last, state_q == sfp_pkg::S_IDLE,
                   "last pixel did not end the star")

endmodule
